[sv/cra_pkg.sv]
// Shared types and constants for the contiguous ring allocator.
// No dependencies; imported by cra_ctrl, cra_datapath and the top level.
`default_nettype none

package cra_pkg;

   // Fixed widths of the transaction fields
   localparam int FIELD_BITS = 16;

   // Defaults for the top-level parameters and the capacity register
   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int CAPACITY_RESET      = 65535;

   // Command codes
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BAD_LENGTH   = 2'd1,
      ST_NO_SPACE     = 2'd2,
      ST_LEN_MISMATCH = 2'd3
   } status_type;

   // Request transaction
   typedef struct packed {
      logic                  cmd;
      logic [FIELD_BITS-1:0] region_offset;
      logic [FIELD_BITS-1:0] length;
   } req_type;

   // Response transaction
   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] alloc_offset_out;
      logic [FIELD_BITS-1:0] used_bytes;
      logic                  unexpected_release_addr;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CALC,
      FSM_REDUCE,
      FSM_DIV,
      FSM_COMMIT,
      FSM_DONE
   } fsm_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic calc;
      logic reduce;
      logic div_step;
      logic commit;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_reduce;
      logic need_commit;
      logic quick;
      logic div_last;
   } dp_sts_type;

endpackage

`default_nettype wire

[sv/cra_ctrl.sv]
// Controller state machine of the contiguous ring allocator.
// Depends on cra_pkg; drives the datapath through dp_cmd_type commands.
`default_nettype none

module cra_ctrl import cra_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = FSM_CALC;
            end
         end
         FSM_CALC: begin
            cmd.calc = 1'b1;
            if (sts.need_reduce) begin
               state_in = FSM_REDUCE;
            end else if (sts.need_commit) begin
               state_in = FSM_COMMIT;
            end else begin
               state_in = FSM_DONE;
            end
         end
         FSM_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = sts.quick ? FSM_COMMIT : FSM_DIV;
         end
         FSM_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = FSM_COMMIT;
            end
         end
         FSM_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = FSM_DONE;
         end
         FSM_DONE: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Output valid: set on load, cleared when the transaction completes
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == FSM_CALC))
      else $error("accepted request did not start calculation");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == FSM_DONE))
      else $error("response raised outside the done state");

   a_quick_skips_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_REDUCE && sts.quick) |=> (state_ff == FSM_COMMIT))
      else $error("quick reduction entered the remainder loop");
`endif

endmodule

`default_nettype wire

[sv/cra_datapath.sv]
// Datapath of the contiguous ring allocator: pointers, capacity, remainder unit.
// Depends on cra_pkg; sequenced by cra_ctrl through dp_cmd_type commands.
`default_nettype none

module cra_datapath import cra_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [FIELD_BITS-1:0] csr_wr_data,
   input  wire req_type               req_data,
   input  wire dp_cmd_type            cmd,
   output dp_sts_type                 sts,
   output rsp_type                    rsp_data
);

   localparam int W  = OFFSET_BITS;     // offset width
   localparam int P  = W + 1;           // pointer width, may hold the ring size
   localparam int S  = W + 2;           // signed free-space width
   localparam int D  = W + 2;           // remainder dividend width
   localparam int CW = $clog2(D);
   localparam logic [W-1:0] OFS_MAX = '1;

   // Allocator state
   logic [W-1:0] cap_ff, cap_in;
   logic [P-1:0] alloc_ptr_ff, alloc_ptr_in;
   logic [P-1:0] release_ptr_ff, release_ptr_in;
   logic [W-1:0] wrap_padding_ff, wrap_padding_in;

   // Working registers of one transaction
   logic         cmd_ff, cmd_in;
   logic [W-1:0] addr_ff, addr_in;
   logic [W-1:0] len_ff, len_in;
   logic [D-1:0] div_ff, div_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [P-1:0] nr_ff, nr_in;
   status_type   res_status_ff, res_status_in;
   logic [P-1:0] res_offset_ff, res_offset_in;
   logic         res_flag_ff, res_flag_in;
   rsp_type      rsp_ff, rsp_in;

   // Derived values
   logic [P-1:0]        ring;
   logic [P-1:0]        len_p;
   logic                wrapped;
   logic                len_bad;
   logic signed [S-1:0] len_s;
   logic signed [S-1:0] free1;
   logic signed [S-1:0] free2;
   logic [P-1:0]        base;
   logic                fits1;
   logic                fits2;
   logic [W-1:0]        pad_new;
   logic                over_release;
   logic [P-1:0]        sum;
   logic                sum_over;
   logic                mod_needed;
   logic [D-1:0]        dividend;
   logic [D-1:0]        ring_d;
   logic                quick;
   logic [D-1:0]        quick_rem;
   logic [P-1:0]        trial;
   logic [W-1:0]        rem_next;
   logic                in_gap;
   logic [S-1:0]        used_raw;
   logic [W-1:0]        used_sat;

   // Ring geometry and the allocate checks
   always_comb begin
      ring     = {1'b0, cap_ff} + P'(1);
      len_p    = P'(len_ff);
      len_s    = S'(len_ff);
      wrapped  = alloc_ptr_ff < release_ptr_ff;
      len_bad  = (len_p >= ring) || (cmd_ff == CMD_ALLOC && len_ff == '0);
      free1    = S'(ring) - S'(alloc_ptr_ff) - S'(release_ptr_ff == '0);
      fits1    = !wrapped && (free1 >= len_s);
      pad_new  = free1[S-1] ? '0 : free1[W-1:0];
      base     = wrapped ? alloc_ptr_ff : '0;
      free2    = S'(release_ptr_ff) - S'(base) - S'(1);
      fits2    = free2 >= len_s;
   end

   // Release end and its reduction modulo the ring size
   always_comb begin
      over_release = (alloc_ptr_ff - release_ptr_ff) < len_p;
      sum          = P'(addr_ff) + P'(len_ff);
      sum_over     = sum > ring;
      mod_needed   = wrapped || sum_over;
      dividend     = (sum_over && wrapped) ? D'(sum) + D'(wrap_padding_ff) : D'(sum);
      ring_d       = D'(ring);
      quick        = div_ff < (ring_d << 1);
      quick_rem    = (div_ff >= ring_d) ? div_ff - ring_d : div_ff;
      // one restoring remainder step: bring down the next dividend bit
      trial        = {rem_ff, div_ff[D-1]};
      rem_next     = (trial >= ring) ? W'(trial - ring) : W'(trial);
      in_gap       = (nr_ff > alloc_ptr_ff) && (nr_ff < release_ptr_ff);
   end

   // Bytes in use, saturated to the offset range
   always_comb begin
      if (wrapped) begin
         used_raw = S'(alloc_ptr_ff) + S'(ring) - S'(release_ptr_ff);
      end else begin
         used_raw = S'(alloc_ptr_ff) - S'(release_ptr_ff);
      end
      used_sat = (used_raw > S'(OFS_MAX)) ? OFS_MAX : W'(used_raw);
   end

   // Status to the controller, valid in the calculation step
   always_comb begin
      sts.need_reduce = 1'b0;
      sts.need_commit = 1'b0;
      if (cmd_ff == CMD_RELEASE && !len_bad && !(!wrapped && over_release)) begin
         sts.need_reduce = mod_needed;
         sts.need_commit = !mod_needed;
      end
      sts.quick    = quick;
      sts.div_last = (cnt_ff == '0);
   end

   // Next value of the allocator state
   always_comb begin
      cap_in          = cap_ff;
      alloc_ptr_in    = alloc_ptr_ff;
      release_ptr_in  = release_ptr_ff;
      wrap_padding_in = wrap_padding_ff;
      if (csr_wr_en) begin
         // new capacity re-creates an empty buffer
         cap_in          = W'(csr_wr_data);
         alloc_ptr_in    = '0;
         release_ptr_in  = '0;
         wrap_padding_in = '0;
      end else begin
         if (cmd.calc && cmd_ff == CMD_ALLOC && !len_bad) begin
            if (fits1) begin
               alloc_ptr_in = alloc_ptr_ff + len_p;
            end else if (fits2) begin
               alloc_ptr_in    = base + len_p;
               wrap_padding_in = wrapped ? wrap_padding_ff : pad_new;
            end
         end
         if (cmd.commit) begin
            if (!wrapped) begin
               release_ptr_in = nr_ff;
            end else if (!in_gap) begin
               // padding is spent once the release side passes the wrap
               if (nr_ff <= alloc_ptr_ff) begin
                  wrap_padding_in = '0;
               end
               release_ptr_in = nr_ff;
            end
         end
      end
   end

   // Next value of the working registers
   always_comb begin
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      nr_in         = nr_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      res_flag_in   = res_flag_ff;
      rsp_in        = rsp_ff;

      if (cmd.load_req) begin
         cmd_in  = req_data.cmd;
         addr_in = W'(req_data.region_offset);
         len_in  = W'(req_data.length);
      end

      if (cmd.calc) begin
         res_status_in = ST_OK;
         res_offset_in = '0;
         res_flag_in   = 1'b0;
         nr_in         = sum;
         div_in        = dividend;
         if (len_bad) begin
            res_status_in = ST_BAD_LENGTH;
         end else if (cmd_ff == CMD_ALLOC) begin
            if (fits1) begin
               res_offset_in = alloc_ptr_ff;
            end else if (fits2) begin
               res_offset_in = base;
            end else begin
               res_status_in = ST_NO_SPACE;
            end
         end else begin
            res_flag_in = (P'(addr_ff) != release_ptr_ff) && (addr_ff != '0);
            if (!wrapped && over_release) begin
               res_status_in = ST_LEN_MISMATCH;
            end
         end
      end

      // reduction: one subtract when the dividend is below twice the ring
      if (cmd.reduce) begin
         if (quick) begin
            nr_in = P'(quick_rem);
         end else begin
            rem_in = '0;
            cnt_in = CW'(D - 1);
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_next;
         div_in = div_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         nr_in  = P'(rem_next);
      end

      if (cmd.commit && wrapped && in_gap) begin
         res_status_in = ST_LEN_MISMATCH;
      end

      if (cmd.load_rsp) begin
         rsp_in.status                  = res_status_ff;
         rsp_in.alloc_offset_out        = FIELD_BITS'(res_offset_ff);
         rsp_in.used_bytes              = FIELD_BITS'(used_sat);
         rsp_in.unexpected_release_addr = res_flag_ff;
      end
   end

   // Allocator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff          <= W'(CAPACITY_RESET);
         alloc_ptr_ff    <= '0;
         release_ptr_ff  <= '0;
         wrap_padding_ff <= '0;
      end else begin
         cap_ff          <= cap_in;
         alloc_ptr_ff    <= alloc_ptr_in;
         release_ptr_ff  <= release_ptr_in;
         wrap_padding_ff <= wrap_padding_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      nr_ff         <= nr_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      res_flag_ff   <= res_flag_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (alloc_ptr_ff <= ring) && (release_ptr_ff <= ring))
      else $error("pointer beyond the ring size");

   a_pad_only_wrapped: assert property (@(posedge clock) disable iff (reset)
      (wrap_padding_ff != '0) |-> (alloc_ptr_ff < release_ptr_ff))
      else $error("wrap padding held while not wrapped");

   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_ff.status == ST_OK || rsp_ff.alloc_offset_out == '0))
      else $error("failed transaction reports an offset");
`endif

endmodule

`default_nettype wire

[sv/contiguous_ring_allocator.sv]
// Top level of the contiguous ring allocator.
// Depends on cra_pkg, cra_ctrl and cra_datapath.
`default_nettype none

// Hands out contiguous regions of a ring of capacity+1 bytes and takes them
// back in FIFO order; offsets are relative to the buffer base. One request is
// worked on at a time, and a finished response waits in an output register so
// the next request can be taken meanwhile. Steps per request: allocates, and
// releases turned away before any pointer math (bad length, or more than is in
// use while not wrapped), go from the calculation step to the done state; a
// release whose end needs no reduction adds a commit step; a release reduced
// by one subtract adds a reduce step before the commit; any other release also
// runs the bit-serial remainder unit, which reduces the release end modulo the
// ring size one bit per cycle. A wrapped release whose end lands inside the
// live span is reported in the commit step, after the reduction. A finished
// request waits in the done state for as long as the previous response sits
// stalled in the output register.
// Writing the capacity register empties the buffer.
module contiguous_ring_allocator import cra_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // capacity register
   input  wire logic                  csr_wr_en,
   input  wire logic [FIELD_BITS-1:0] csr_wr_data,
   // request transactions
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // response transactions
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // Sequencer
   cra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   // Pointers, checks and remainder unit
   cra_datapath #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (dp_cmd),
      .sts         (dp_sts),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for contiguous_ring_allocator: a random and directed
// stream of alloc/release transactions, checked against a cycle-free ring model.
// Depends on cra_pkg and the contiguous_ring_allocator RTL.

module testbench import cra_pkg::*;;

   localparam int OFS            = OFFSET_BITS_DEFAULT;
   localparam int PTR_BITS       = OFS + 1;
   localparam int OFS_MASK       = (1 << OFS) - 1;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Ring bookkeeping; pointers are one bit wider since they may equal the ring size
   typedef struct packed {
      logic [FIELD_BITS-1:0] capacity;
      logic [PTR_BITS-1:0]   head;
      logic [PTR_BITS-1:0]   tail;
      logic [OFS-1:0]        pad;
   } ring_state_type;

   // One granted region, kept in grant order
   typedef struct packed {
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] span;
   } region_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    csr_wr_en   = 1'b0;
   logic [FIELD_BITS-1:0] csr_wr_data = '0;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;

   ring_state_type dut_view;      // follows accepted transactions
   ring_state_type plan_view;     // follows generated transactions
   region_type     live_regions[$];
   req_type        cmd_backlog[$];
   rsp_type        ring_replies[$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   bit   idle_on   = 1'b1;
   int   req_gap   = 0;
   int   rsp_wait  = 0;
   int   n_issued  = 0;
   int   n_accepted = 0;
   int   n_checked = 0;
   int   fault_count = 0;
   int   quiet_cycles = 0;
   int   settings_used = 1;
   int   flagged_seen = 0;
   int   status_seen[4] = '{0, 0, 0, 0};

   contiguous_ring_allocator #(.OFFSET_BITS(OFS)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #1 clock = ~clock;

   // Ring behavior: one transaction in, one response out, state updated in place
   function automatic rsp_type ring_transact(inout ring_state_type s, input req_type r);
      int      ring, len, addr, head, tail, pad, room, base, new_pad, sum, nr, used;
      bit      placed;
      rsp_type o;
      ring   = (int'(s.capacity) & OFS_MASK) + 1;
      len    = int'(r.length) & OFS_MASK;
      addr   = int'(r.region_offset) & OFS_MASK;
      head   = int'(s.head);
      tail   = int'(s.tail);
      pad    = int'(s.pad);
      o      = '0;
      placed = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
         if (len == 0 || len >= ring) begin
            o.status = ST_BAD_LENGTH;
         end else begin
            base    = head;
            new_pad = pad;
            // not wrapped: try the tail first, else skip it as padding
            if (head >= tail) begin
               room = ring - head - ((tail == 0) ? 1 : 0);
               if (room >= len) begin
                  o.alloc_offset_out = FIELD_BITS'(head);
                  head   = head + len;
                  placed = 1'b1;
               end else begin
                  new_pad = (room < 0) ? 0 : room;
                  base    = 0;
               end
            end
            if (!placed) begin
               room = tail - base - 1;
               if (room >= len) begin
                  o.alloc_offset_out = FIELD_BITS'(base);
                  head = base + len;
                  pad  = new_pad;
               end else begin
                  o.status = ST_NO_SPACE;
               end
            end
         end
      end else begin
         if (len >= ring) begin
            o.status = ST_BAD_LENGTH;
         end else begin
            o.unexpected_release_addr = (addr != tail) && (addr != 0);
            sum = addr + len;
            if (head >= tail) begin
               if (head - tail < len) o.status = ST_LEN_MISMATCH;
               else tail = (sum > ring) ? sum % ring : sum;
            end else begin
               // wrapped: an end past the ring also covers the skipped tail
               nr = (sum > ring) ? (sum + pad) % ring : sum % ring;
               if (nr > head && nr < tail) begin
                  o.status = ST_LEN_MISMATCH;
               end else begin
                  if (nr <= head) pad = 0;
                  tail = nr;
               end
            end
         end
      end
      used = (head >= tail) ? head - tail : head + ring - tail;
      if (used > OFS_MASK) used = OFS_MASK;
      o.used_bytes = FIELD_BITS'(used);
      s.head = PTR_BITS'(head);
      s.tail = PTR_BITS'(tail);
      s.pad  = OFS'(pad);
      return o;
   endfunction

   function automatic req_type ring_cmd(input logic c, input int ofs, input int len);
      req_type r;
      r.cmd           = c;
      r.region_offset = FIELD_BITS'(ofs);
      r.length        = FIELD_BITS'(len);
      return r;
   endfunction

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", what);
   endtask

   // Queue one transaction and advance the planning copy of the ring
   task automatic issue(input req_type r);
      rsp_type    res;
      region_type reg_entry;
      res = ring_transact(plan_view, r);
      if (res.status == ST_OK) begin
         if (r.cmd == CMD_ALLOC) begin
            reg_entry.start = res.alloc_offset_out;
            reg_entry.span  = r.length;
            live_regions.push_back(reg_entry);
         end else if (live_regions.size() != 0 &&
                      live_regions[0].start == r.region_offset) begin
            void'(live_regions.pop_front());
         end
      end
      cmd_backlog.push_back(r);
      n_issued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (n_accepted != n_issued || ring_replies.size() != 0);
   endtask

   // Capacity write while idle; it also empties the ring
   task automatic set_capacity(input int cap);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FIELD_BITS'(cap);
      plan_view          = '0;
      plan_view.capacity = FIELD_BITS'(cap);
      dut_view           = plan_view;
      live_regions.delete();
      settings_used++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic plan_one(input bit chaos);
      int             ring, roll, len;
      req_type        r;
      ring_state_type trial;
      rsp_type        res;
      ring = int'(plan_view.capacity) + 1;
      roll = $urandom_range(0, 99);
      if (chaos) begin
         // unconstrained mix, release offsets biased to the release pointer and 0
         case ($urandom_range(0, 2))
            0:       r.region_offset = FIELD_BITS'(plan_view.tail);
            1:       r.region_offset = '0;
            default: r.region_offset = FIELD_BITS'($urandom);
         endcase
         r.cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_RELEASE;
         if (roll < 50)      r.length = FIELD_BITS'($urandom_range(0, 8));
         else if (roll < 85) r.length = FIELD_BITS'($urandom_range(0, ring));
         else                r.length = FIELD_BITS'($urandom);
      end else if (roll < 10) begin
         // broken transaction, kept only when the ring must reject it
         case ($urandom_range(0, 4))
            0: r = ring_cmd(CMD_ALLOC, $urandom, 0);
            1: r = ring_cmd(CMD_ALLOC, $urandom, $urandom_range(ring, OFS_MASK));
            2: r = ring_cmd(CMD_RELEASE, int'(plan_view.tail),
                            $urandom_range(ring, OFS_MASK));
            3: begin
               if (live_regions.size() != 0)
                  r = ring_cmd(CMD_RELEASE, live_regions[0].start,
                               live_regions[0].span + $urandom_range(1, ring));
               else
                  r = ring_cmd(CMD_RELEASE, $urandom, $urandom);
            end
            default: r = ring_cmd(CMD_RELEASE, $urandom, $urandom);
         endcase
         trial = plan_view;
         res = ring_transact(trial, r);
         if (res.status == ST_OK) r = ring_cmd(CMD_ALLOC, $urandom, 0);
      end else if (live_regions.size() != 0 && roll < 55) begin
         r = ring_cmd(CMD_RELEASE, live_regions[0].start, live_regions[0].span);
      end else begin
         roll = $urandom_range(0, 9);
         if (roll < 7)      len = $urandom_range(1, (ring / 8 > 1) ? ring / 8 : 1);
         else if (roll < 9) len = $urandom_range(1, (ring / 2 > 1) ? ring / 2 : 1);
         else               len = $urandom_range(1, ring - 1);
         r = ring_cmd(CMD_ALLOC, $urandom, len);
      end
      issue(r);
   endtask

   // Bursts of random transactions, sometimes letting the ring drain in between
   task automatic random_part(input bit chaos, input int n_items);
      int done_items;
      done_items = 0;
      while (done_items < n_items) begin
         @(posedge clock);
         idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(10, 30)) begin
            if (done_items < n_items) begin
               plan_one(chaos);
               done_items++;
            end
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
         else while (cmd_backlog.size() > 4) @(posedge clock);
      end
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            req_data  <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap = idle_on ? $urandom_range(0, 4) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = idle_on ? $urandom_range(0, 4) : 0;
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    req_fire, rsp_fire;
      req_fire = req_valid && !req_stall;
      rsp_fire = rsp_valid && !rsp_stall;
      req_taken <= req_fire && !reset;
      rsp_taken <= rsp_fire && !reset;
      if (!reset) begin
         if (rsp_fire) begin
            if (ring_replies.size() == 0) begin
               report_fault($sformatf("%0t: response with no request outstanding", $realtime));
            end else begin
               want = ring_replies.pop_front();
               n_checked++;
               status_seen[want.status]++;
               if (want.unexpected_release_addr) flagged_seen++;
               if (rsp_data.status !== want.status ||
                   rsp_data.alloc_offset_out !== want.alloc_offset_out ||
                   rsp_data.used_bytes !== want.used_bytes ||
                   rsp_data.unexpected_release_addr !== want.unexpected_release_addr)
                  report_fault($sformatf({"%0t: response %0d mismatch: expected ",
                     "status %0d offset %0d used %0d flag %0b, got status %0d ",
                     "offset %0d used %0d flag %0b"}, $realtime, n_checked,
                     want.status, want.alloc_offset_out, want.used_bytes,
                     want.unexpected_release_addr, rsp_data.status,
                     rsp_data.alloc_offset_out, rsp_data.used_bytes,
                     rsp_data.unexpected_release_addr));
            end
         end
         if (req_fire) begin
            ring_replies.push_back(ring_transact(dut_view, req_data));
            n_accepted++;
         end
         if (req_fire || rsp_fire) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      dut_view          = '0;
      dut_view.capacity = FIELD_BITS'(CAPACITY_RESET);
      plan_view         = dut_view;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset capacity: field extremes, no-space, saturated used count,
      // unexpected release whose end runs past the ring
      issue(ring_cmd(CMD_ALLOC, 16'hFFFF, 0));
      issue(ring_cmd(CMD_ALLOC, 0, 10));
      issue(ring_cmd(CMD_RELEASE, 0, 10));
      issue(ring_cmd(CMD_ALLOC, 0, 65526));
      issue(ring_cmd(CMD_RELEASE, 0, 0));
      issue(ring_cmd(CMD_ALLOC, 0, 1));
      issue(ring_cmd(CMD_RELEASE, 16'hFFFF, 16'hFFFF));

      // Small ring: bad lengths, tail skip with padding, wrapped mismatch,
      // padded release, unwrapped mismatch, unexpected offsets
      set_capacity(15);
      issue(ring_cmd(CMD_ALLOC, 0, 16));
      issue(ring_cmd(CMD_RELEASE, 0, 16));
      issue(ring_cmd(CMD_ALLOC, 0, 5));
      issue(ring_cmd(CMD_ALLOC, 0, 6));
      issue(ring_cmd(CMD_RELEASE, 0, 5));
      issue(ring_cmd(CMD_ALLOC, 0, 7));
      issue(ring_cmd(CMD_ALLOC, 0, 4));
      issue(ring_cmd(CMD_ALLOC, 0, 3));
      issue(ring_cmd(CMD_RELEASE, 5, 6));
      issue(ring_cmd(CMD_RELEASE, 0, 5));
      issue(ring_cmd(CMD_RELEASE, 11, 4));
      issue(ring_cmd(CMD_RELEASE, 15, 3));
      issue(ring_cmd(CMD_RELEASE, 3, 1));
      issue(ring_cmd(CMD_RELEASE, 9, 0));
      issue(ring_cmd(CMD_RELEASE, 15, 15));

      // Random phases across capacity settings, extremes included
      set_capacity(65535);
      random_part(1'b0, 180);
      set_capacity(15);
      random_part(1'b0, 180);
      set_capacity(1);
      random_part(1'b0, 100);
      set_capacity(100);
      random_part(1'b0, 180);
      set_capacity(65535);
      random_part(1'b1, 130);
      set_capacity(2);
      random_part(1'b1, 90);
      set_capacity(4096);
      random_part(1'b0, 140);
      set_capacity(65534);
      random_part(1'b0, 90);
      set_capacity($urandom_range(3, 65533));
      random_part(1'b0, 90);
      set_capacity(7);
      random_part(1'b1, 70);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Checked %0d responses over %0d capacity settings, %0d at unexpected offsets",
               n_checked, settings_used, flagged_seen);
      $display("Status mix: ok %0d, bad length %0d, no space %0d, length mismatch %0d",
               status_seen[ST_OK], status_seen[ST_BAD_LENGTH], status_seen[ST_NO_SPACE],
               status_seen[ST_LEN_MISMATCH]);
      if (fault_count == 0 && ring_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", fault_count,
                  ring_replies.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
